// ===== hdl/olad_pkg.sv =====
// shared types and constants for the ordered list with append and delete-at
package olad_pkg;

    // default list depth
    localparam int DEPTH_DEF = 32;

    // fixed field widths
    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;

    // command codes
    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_SHOW   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 3'd0,
        STAT_EMPTY = 3'd1,
        STAT_SHORT = 3'd2,
        STAT_FULL  = 3'd3,
        STAT_SHOWN = 3'd4
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DEL_DONE,
        ST_SHOW_RD,
        ST_SHOW_OUT
    } state_t;

endpackage

// ===== hdl/ordered_list_append_delete_at.sv =====
// ordered list of signed values with append, delete at position and show
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------
//   in      | input     | in_valid/in_stall   | kind, value, position
//   out     | output    | out_valid/out_stall | status, element, last
//
// append and every flagged command give one beat from idle
// delete at position p of n elements moves the n-p following elements up one
// place through the one list memory read port, a read state then a write
// state each; show of n elements gives n beats, one memory read per beat;
// reset clears the element count and control, not the list memory
// a stalled output holds its beat and the sequencer waits behind it
module ordered_list_append_delete_at #(
    parameter int DEPTH = olad_pkg::DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic        [olad_pkg::KIND_W-1:0]   kind,
    input  logic signed [olad_pkg::VALUE_W-1:0]  value,
    input  logic        [olad_pkg::POS_W-1:0]    position,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic        [olad_pkg::STATUS_W-1:0] status,
    output logic signed [olad_pkg::VALUE_W-1:0]  element,
    output logic                                 last
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int AW   = $clog2(DEPTH);
    localparam int CMPW = ((CW > olad_pkg::POS_W) ? CW : olad_pkg::POS_W) + 1;

    // list memory and its registered read data
    logic signed [olad_pkg::VALUE_W-1:0] list_mem [DEPTH];
    logic signed [olad_pkg::VALUE_W-1:0] rd_data_reg;
    logic        [AW-1:0]                rd_addr;
    logic                                mem_we;
    logic        [AW-1:0]                mem_waddr;
    logic signed [olad_pkg::VALUE_W-1:0] mem_wdata;

    // control state
    olad_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    idx_reg, idx_next;

    // output register
    logic                                out_valid_reg, out_valid_next;
    olad_pkg::status_t                   status_reg, status_next;
    logic signed [olad_pkg::VALUE_W-1:0] element_reg, element_next;
    logic                                last_reg, last_next;

    logic             out_free;
    logic             in_accept;
    olad_pkg::kind_t  kind_in;
    logic [CMPW-1:0]  pos_ext;
    logic [CMPW-1:0]  count_ext;
    logic [CMPW-1:0]  idx_ext;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != olad_pkg::ST_IDLE) || !out_free;
    assign in_accept = in_valid && !in_stall;
    assign kind_in   = olad_pkg::kind_t'(kind);
    assign pos_ext   = CMPW'(position);
    assign count_ext = CMPW'(count_reg);
    assign idx_ext   = CMPW'(idx_reg);

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign element   = element_reg;
    assign last      = last_reg;

    // read address: next element while shifting, current one otherwise
    always_comb
    begin
        if (state_reg == olad_pkg::ST_SHIFT_RD)
        begin
            rd_addr = AW'(idx_ext + CMPW'(1));
        end
        else
        begin
            rd_addr = idx_reg;
        end
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            list_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= list_mem[rd_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= olad_pkg::ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        element_reg <= element_next;
        last_reg    <= last_next;
    end

    // sequencer: next state, memory writes and output beats
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        element_next   = element_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = rd_data_reg;

        unique case (state_reg)
            olad_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (kind_in)
                        olad_pkg::KIND_APPEND:
                        begin
                            out_valid_next = 1'b1;
                            element_next   = '0;
                            last_next      = 1'b1;
                            if (count_ext >= CMPW'(DEPTH))
                            begin
                                status_next = olad_pkg::STAT_FULL;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = AW'(count_reg);
                                mem_wdata   = value;
                                count_next  = CW'(count_ext + CMPW'(1));
                                status_next = olad_pkg::STAT_DONE;
                            end
                        end
                        olad_pkg::KIND_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = olad_pkg::STAT_EMPTY;
                                element_next   = '0;
                                last_next      = 1'b1;
                            end
                            else if (position == '0 || pos_ext > count_ext)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = olad_pkg::STAT_SHORT;
                                element_next   = '0;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                idx_next = AW'(pos_ext - CMPW'(1));
                                if (pos_ext < count_ext)
                                begin
                                    state_next = olad_pkg::ST_SHIFT_RD;
                                end
                                else
                                begin
                                    state_next = olad_pkg::ST_DEL_DONE;
                                end
                            end
                        end
                        olad_pkg::KIND_SHOW:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = olad_pkg::STAT_EMPTY;
                                element_next   = '0;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = olad_pkg::ST_SHOW_RD;
                            end
                        end
                        default:
                        begin
                            // unused command: no beat, no change
                        end
                    endcase
                end
            end

            olad_pkg::ST_SHIFT_RD:
            begin
                state_next = olad_pkg::ST_SHIFT_WR;
            end

            // move the following element up one place
            olad_pkg::ST_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = rd_data_reg;
                idx_next  = AW'(idx_ext + CMPW'(1));
                if (idx_ext + CMPW'(2) < count_ext)
                begin
                    state_next = olad_pkg::ST_SHIFT_RD;
                end
                else
                begin
                    state_next = olad_pkg::ST_DEL_DONE;
                end
            end

            olad_pkg::ST_DEL_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = olad_pkg::STAT_DONE;
                    element_next   = '0;
                    last_next      = 1'b1;
                    count_next     = CW'(count_ext - CMPW'(1));
                    state_next     = olad_pkg::ST_IDLE;
                end
            end

            olad_pkg::ST_SHOW_RD:
            begin
                state_next = olad_pkg::ST_SHOW_OUT;
            end

            // one beat per element, held until the output is free
            olad_pkg::ST_SHOW_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = olad_pkg::STAT_SHOWN;
                    element_next   = rd_data_reg;
                    if (idx_ext + CMPW'(1) == count_ext)
                    begin
                        last_next  = 1'b1;
                        state_next = olad_pkg::ST_IDLE;
                    end
                    else
                    begin
                        last_next  = 1'b0;
                        idx_next   = AW'(idx_ext + CMPW'(1));
                        state_next = olad_pkg::ST_SHOW_RD;
                    end
                end
            end

            default:
            begin
                state_next = olad_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
